// File: rtl/rasi_pkg.sv
// package: float32 helpers for the ray box slab test
`timescale 1ns / 1ps
`default_nettype none
package rasi_pkg;
  localparam logic [31:0] CanonNan = 32'h7FC00000;

  function automatic logic is_nan(input logic [31:0] a);
    is_nan = (a[30:23] == 8'hFF) && (a[22:0] != '0);
  endfunction

  // ordered a < b, false on nan
  function automatic logic flt_lt(input logic [31:0] a, input logic [31:0] b);
    logic az;
    az = (a[30:0] == '0) && (b[30:0] == '0);
    if (is_nan(a) || is_nan(b) || az) flt_lt = 1'b0;
    else if (a[31] != b[31]) flt_lt = a[31];
    else if (a[31]) flt_lt = a[30:0] > b[30:0];
    else flt_lt = a[30:0] < b[30:0];
  endfunction

  // round-to-nearest-even pack: sign, unbiased-style biased exponent (signed),
  // mantissa with leading one at bit 26 plus sticky in lower bits
  function automatic logic [31:0] rnd_pack(input logic s, input logic signed [11:0] e,
                                           input logic [26:0] m);
    logic [26:0] mm;
    logic signed [11:0] ee;
    logic [5:0] sh;
    logic stk;
    logic [24:0] r;
    logic lsb, g, rest;
    mm = m;
    ee = e;
    if (ee < 12'sd1) begin
      sh = (12'sd1 - ee > 12'sd27) ? 6'd27 : 6'(12'sd1 - ee);
      stk = 1'b0;
      for (int i = 0; i < 27; i++) if (i < sh && mm[i]) stk = 1'b1;
      mm = (mm >> sh) | {26'd0, stk};
      ee = 12'sd0;
    end
    lsb = mm[3]; g = mm[2]; rest = |mm[1:0];
    r = {1'b0, mm[26:3]} + {24'd0, g & (lsb | rest)};
    if (r[24]) begin
      r = r >> 1;
      ee = ee + 12'sd1;
    end else if (ee == 12'sd0 && r[23]) begin
      ee = 12'sd1;
    end
    if (ee >= 12'sd255) rnd_pack = {s, 8'hFF, 23'd0};
    else rnd_pack = {s, ee[7:0], r[22:0]};
  endfunction
endpackage
`default_nettype wire

// File: rtl/ray_aabb_slab_intersect_core.sv
// ray versus axis-aligned box slab test, float32, six-stage pipeline
// six register stages; the fp add and multiply are split over stages
// throughput: one item per cycle unless out_stall_i holds with every stage full
// stall: per-stage enables, a stage holds only while it and every later stage are full,
//   bubbles are squeezed so the input is taken while any stage is empty
// reset: all valid bits clear; payload registers are not reset
`timescale 1ns / 1ps
`default_nettype none
module ray_aabb_slab_intersect_core
  import rasi_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire logic [31:0] box_min_x_i,
  input  wire logic [31:0] box_min_y_i,
  input  wire logic [31:0] box_min_z_i,
  input  wire logic [31:0] box_max_x_i,
  input  wire logic [31:0] box_max_y_i,
  input  wire logic [31:0] box_max_z_i,
  input  wire logic [31:0] origin_x_i,
  input  wire logic [31:0] origin_y_i,
  input  wire logic [31:0] origin_z_i,
  input  wire logic [31:0] inv_dir_x_i,
  input  wire logic [31:0] inv_dir_y_i,
  input  wire logic [31:0] inv_dir_z_i,
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      logic        hit_o,
  output      logic [31:0] t_near_o,
  output      logic [31:0] t_far_o
);
  localparam int unsigned NSt = 6;

  // per-stage enable: stage k loads when it is empty or its successor loads
  logic [NSt-1:0] vld_q;
  logic [NSt:0]   adv;
  always_comb begin
    adv[NSt] = ~out_stall_i;
    for (int k = NSt - 1; k >= 0; k--) adv[k] = ~vld_q[k] | adv[k+1];
  end
  assign in_stall_o = ~adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k < NSt; k++) if (adv[k]) vld_q[k] <= vld_q[k-1];
    end
  end

  // ---------------- stage 1: subtract align (6 lanes) ----------------
  typedef struct packed {
    logic               s;
    logic signed [11:0] e;
    logic [27:0]        a;   // larger operand, leading one at bit 26
    logic [27:0]        b;   // smaller, aligned with sticky
    logic               sub;
    logic [31:0]        spec; // special result
    logic               use_spec;
  } add_t;

  function automatic add_t add_align(input logic [31:0] x, input logic [31:0] y0);
    add_t r;
    logic [31:0] y, p, q;
    logic [26:0] mp, mq;
    logic [7:0] ep, eq;
    logic [7:0] d;
    logic [26:0] sh;
    logic stk;
    y = {~y0[31], y0[30:0]};
    r = '0;
    if (is_nan(x) || is_nan(y)) begin
      r.use_spec = 1'b1; r.spec = CanonNan;
    end else if (x[30:23] == 8'hFF && y[30:23] == 8'hFF) begin
      r.use_spec = 1'b1; r.spec = (x[31] == y[31]) ? x : CanonNan;
    end else if (x[30:23] == 8'hFF) begin
      r.use_spec = 1'b1; r.spec = x;
    end else if (y[30:23] == 8'hFF) begin
      r.use_spec = 1'b1; r.spec = y;
    end else if (x[30:0] == '0 && y[30:0] == '0) begin
      r.use_spec = 1'b1; r.spec = {x[31] & y[31], 31'd0};
    end
    if (x[30:0] >= y[30:0]) begin p = x; q = y; end else begin p = y; q = x; end
    ep = (p[30:23] == 0) ? 8'd1 : p[30:23];
    eq = (q[30:23] == 0) ? 8'd1 : q[30:23];
    mp = {(p[30:23] != 0), p[22:0], 3'b000};
    mq = {(q[30:23] != 0), q[22:0], 3'b000};
    d = ep - eq;
    if (d > 8'd27) begin
      sh = '0; stk = |mq;
    end else begin
      sh = mq >> d;
      stk = |(mq & ~(27'h7FFFFFF << d));
    end
    r.s = p[31];
    r.e = 12'(ep);
    r.a = {1'b0, mp};
    r.b = {1'b0, sh[26:1], sh[0] | stk};
    r.sub = p[31] ^ q[31];
    // exact cancel gives +0
    if (!r.use_spec && r.sub && x[30:0] == y[30:0]) begin
      r.use_spec = 1'b1; r.spec = 32'd0;
    end
    return r;
  endfunction

  add_t        al_q [6];
  logic [31:0] inv1_q [3];
  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      al_q[0] <= add_align(box_min_x_i, origin_x_i);
      al_q[1] <= add_align(box_min_y_i, origin_y_i);
      al_q[2] <= add_align(box_min_z_i, origin_z_i);
      al_q[3] <= add_align(box_max_x_i, origin_x_i);
      al_q[4] <= add_align(box_max_y_i, origin_y_i);
      al_q[5] <= add_align(box_max_z_i, origin_z_i);
      inv1_q[0] <= inv_dir_x_i;
      inv1_q[1] <= inv_dir_y_i;
      inv1_q[2] <= inv_dir_z_i;
    end
  end

  // ---------------- stage 2: add, normalize, round ----------------
  function automatic logic [31:0] add_fin(input add_t r);
    logic [27:0] m;
    logic [4:0] lz;
    logic found;
    logic [26:0] n;
    logic signed [11:0] e;
    if (r.use_spec) return r.spec;
    m = r.sub ? (r.a - r.b) : (r.a + r.b);
    e = r.e;
    if (m[27]) begin
      n = {m[27:2], m[1] | m[0]};
      e = e + 12'sd1;
    end else begin
      lz = '0; found = 1'b0;
      for (int i = 26; i >= 0; i--) begin
        if (!found && m[i]) begin found = 1'b1; lz = 5'(26 - i); end
      end
      if (12'(lz) > e - 12'sd1) lz = 5'(e - 12'sd1);
      n = m[26:0] << lz;
      e = e - 12'(lz);
      // subnormal result, rescaled so the pack shift restores it
      if (!n[26]) begin
        n = n << 1;
        e = 12'sd0;
      end
    end
    return rnd_pack(r.s, e, n);
  endfunction

  logic [31:0] df_q [6];
  logic [31:0] inv2_q [3];
  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      for (int i = 0; i < 6; i++) df_q[i] <= add_fin(al_q[i]);
      for (int i = 0; i < 3; i++) inv2_q[i] <= inv1_q[i];
    end
  end

  // ---------------- stage 3: multiply mantissas ----------------
  typedef struct packed {
    logic               s;
    logic signed [11:0] e;
    logic [47:0]        p;
    logic               use_spec;
    logic [31:0]        spec;
  } mul_t;

  function automatic mul_t mul_a(input logic [31:0] x, input logic [31:0] y);
    mul_t r;
    logic xz, yz, xi, yi;
    logic [23:0] mx, my;
    r = '0;
    r.s = x[31] ^ y[31];
    xz = x[30:0] == '0; yz = y[30:0] == '0;
    xi = x[30:23] == 8'hFF; yi = y[30:23] == 8'hFF;
    if (is_nan(x) || is_nan(y) || (xi && yz) || (yi && xz)) begin
      r.use_spec = 1'b1; r.spec = CanonNan;
    end else if (xi || yi) begin
      r.use_spec = 1'b1; r.spec = {r.s, 8'hFF, 23'd0};
    end else if (xz || yz) begin
      r.use_spec = 1'b1; r.spec = {r.s, 31'd0};
    end
    mx = {(x[30:23] != 0), x[22:0]};
    my = {(y[30:23] != 0), y[22:0]};
    r.e = 12'((x[30:23] == 0) ? 8'd1 : x[30:23]) + 12'((y[30:23] == 0) ? 8'd1 : y[30:23])
          - 12'sd127;
    r.p = mx * my;
    return r;
  endfunction

  mul_t mp_q [6];
  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      for (int i = 0; i < 6; i++) mp_q[i] <= mul_a(df_q[i], inv2_q[i % 3]);
    end
  end

  // ---------------- stage 4: normalize and round product ----------------
  function automatic logic [31:0] mul_fin(input mul_t r);
    logic [47:0] p;
    logic [5:0] lz;
    logic found;
    logic signed [11:0] e;
    if (r.use_spec) return r.spec;
    p = r.p;
    e = r.e;
    if (p[47]) begin
      e = e + 12'sd1;
    end else begin
      lz = '0; found = 1'b0;
      for (int i = 46; i >= 0; i--) begin
        if (!found && p[i]) begin found = 1'b1; lz = 6'(46 - i); end
      end
      p = p << (lz + 6'd1);
      e = e - 12'(lz);
    end
    return rnd_pack(r.s, e, {p[47:22], |p[21:0]});
  endfunction

  logic [31:0] t_q [6];
  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      for (int i = 0; i < 6; i++) t_q[i] <= mul_fin(mp_q[i]);
    end
  end

  // ---------------- stage 5: per-axis min/max ----------------
  logic [31:0] nr_q [3];
  logic [31:0] fr_q [3];
  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      for (int i = 0; i < 3; i++) begin
        nr_q[i] <= flt_lt(t_q[i+3], t_q[i]) ? t_q[i+3] : t_q[i];
        fr_q[i] <= flt_lt(t_q[i], t_q[i+3]) ? t_q[i+3] : t_q[i];
      end
    end
  end

  // ---------------- stage 6: reduce and hit ----------------
  logic [31:0] tn01, tn, tf01, tf, fl0;
  always_comb begin
    tn01 = flt_lt(nr_q[0], nr_q[1]) ? nr_q[1] : nr_q[0];
    tn   = flt_lt(tn01, nr_q[2]) ? nr_q[2] : tn01;
    tf01 = flt_lt(fr_q[1], fr_q[0]) ? fr_q[1] : fr_q[0];
    tf   = flt_lt(fr_q[2], tf01) ? fr_q[2] : tf01;
    fl0  = flt_lt(tn, 32'd0) ? 32'd0 : tn;
  end

  logic        hit_q;
  logic [31:0] tn_q, tf_q;
  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      hit_q <= !is_nan(tf) && !is_nan(fl0) && !flt_lt(tf, fl0);
      tn_q  <= is_nan(tn) ? CanonNan : tn;
      tf_q  <= is_nan(tf) ? CanonNan : tf;
    end
  end

  assign out_valid_o = vld_q[NSt-1];
  assign hit_o       = hit_q;
  assign t_near_o    = tn_q;
  assign t_far_o     = tf_q;

  property p_hold;
    @(posedge clk_i) disable iff (!rst_ni) out_valid_o && out_stall_i |=> out_valid_o;
  endproperty
  a_hold: assert property (p_hold) else $error("output item dropped under stall");

  property p_nan_nohit;
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && (t_far_o == CanonNan) |-> !hit_o;
  endproperty
  a_nan_nohit: assert property (p_nan_nohit) else $error("hit with nan exit distance");

  property p_in_take;
    @(posedge clk_i) disable iff (!rst_ni) !vld_q[0] |-> !in_stall_o;
  endproperty
  a_in_take: assert property (p_in_take) else $error("stall with empty first stage");
endmodule
`default_nettype wire
